@@ design/sbcs_pkg.sv @@
package sbcs_pkg;

    localparam int IMAGE_SIZE_DEF = 28;
    localparam int MAX_RADIUS_DEF = 7;

    localparam int FUNC_W  = 2;
    localparam int POS_W   = 13;
    localparam int SCALE_W = 7;
    localparam int RAD_W   = 3;
    localparam int VAL_W   = 9;
    localparam int INC_W   = 8;
    localparam int CFG_AW  = 1;
    localparam int CFG_DW  = 7;

    localparam int SCALE_MAX = (1 << SCALE_W) - 1;
    localparam logic [VAL_W-1:0]   PIXEL_FULL   = VAL_W'(256);
    localparam logic [SCALE_W-1:0] SCALE_RESET  = SCALE_W'(10);
    localparam logic [RAD_W-1:0]   RADIUS_RESET = RAD_W'(1);

    localparam logic [FUNC_W-1:0] FUNC_PAINT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    localparam logic [CFG_AW-1:0] CFG_SCALE  = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_RADIUS = 1'b1;

    localparam int LUT_DEPTH = 1 << (3 * RAD_W);

    typedef logic [INC_W-1:0] inc_lut_t [LUT_DEPTH];

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DIV,
        ST_PAINT,
        ST_CLEAR,
        ST_READ,
        ST_RDWAIT,
        ST_FIN
    } state_t;

    // round(140.8 * max(0, 1 - sqrt(s)/r1)), ties up, in exact integers
    function automatic logic [INC_W-1:0] brush_inc(input int s, input int r1);
        longint a;
        int     k;
        bit     stop;
        k    = 0;
        stop = 1'b0;
        for (int j = 1; j <= 141; j++) begin
            if (!stop) begin
                a = longint'(1408 * r1) - longint'(5 * r1 * (2 * j - 1));
                if (a < 0) begin
                    stop = 1'b1;
                end else if (a * a >= longint'(1408 * 1408) * longint'(s)) begin
                    k = j;
                end else begin
                    stop = 1'b1;
                end
            end
        end
        return INC_W'(k);
    endfunction

    function automatic inc_lut_t build_inc_lut();
        inc_lut_t lut;
        int       idx;
        for (int r = 0; r < (1 << RAD_W); r++) begin
            for (int a = 0; a < (1 << RAD_W); a++) begin
                for (int b = 0; b < (1 << RAD_W); b++) begin
                    idx      = (r << (2 * RAD_W)) + (a << RAD_W) + b;
                    lut[idx] = brush_inc(a * a + b * b, r + 1);
                end
            end
        end
        return lut;
    endfunction

    localparam inc_lut_t INC_LUT = build_inc_lut();

endpackage

@@ design/soft_brush_canvas_stamp.sv @@
// Paint: a restoring divider, then one brush pixel per cycle through the canvas RAM
//   read/modify/write pipe; for a position outside the edge the stamp is skipped.
// Clear zeroes the whole canvas. Read returns one pixel; outside the grid or unused code, zeros.
// One command in flight; the next beat is taken once the current result is registered.
// Reset is synchronous, active low; afterwards a sweep over all IMAGE_SIZE^2 pixels zeroes
//   the canvas while no input beat is taken. Config writes are always taken.
module soft_brush_canvas_stamp #(
    parameter int IMAGE_SIZE = sbcs_pkg::IMAGE_SIZE_DEF,
    parameter int MAX_RADIUS = sbcs_pkg::MAX_RADIUS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // pos_x[12:0], pos_y[25:13], zero fill
    input  logic [sbcs_pkg::FUNC_W-1:0] s_tuser,   // func[1:0]

    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,   // pixel_value[8:0], zero fill
    output logic                        m_tuser,   // in_canvas[0]

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sbcs_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [sbcs_pkg::CFG_DW-1:0] cfg_data
);

    localparam int NPIX    = IMAGE_SIZE * IMAGE_SIZE;
    localparam int ADDR_W  = $clog2(NPIX);
    localparam int QW      = $clog2(IMAGE_SIZE);
    localparam int CNT_W   = $clog2(QW);
    localparam int MAG_W   = sbcs_pkg::POS_W - 1;
    localparam int EDGE_W  = $clog2(IMAGE_SIZE * sbcs_pkg::SCALE_MAX + 1);
    localparam int CMP_W   = (EDGE_W > MAG_W) ? EDGE_W : MAG_W;
    localparam int DIV_W   = sbcs_pkg::POS_W + sbcs_pkg::SCALE_W;
    localparam int RAD_W   = sbcs_pkg::RAD_W;
    localparam int OFS_W   = RAD_W + 1;
    localparam int CRD_W   = ((QW > RAD_W) ? QW : RAD_W) + 2;
    localparam int VAL_W   = sbcs_pkg::VAL_W;
    localparam int INC_W   = sbcs_pkg::INC_W;

    sbcs_pkg::state_t state_reg, state_next;

    logic [sbcs_pkg::SCALE_W-1:0] scale_reg;
    logic [RAD_W-1:0]             radius_reg;

    logic                         m_tvalid_reg;
    logic                         out_inside_reg;
    logic [VAL_W-1:0]             out_value_reg;
    logic                         res_inside_reg;
    logic [VAL_W-1:0]             res_value_reg;

    logic [MAG_W-1:0]             rem_x_reg, rem_y_reg;
    logic [QW-1:0]                cx_reg, cy_reg;
    logic [CNT_W-1:0]             div_cnt_reg;
    logic signed [OFS_W-1:0]      dx_reg, dy_reg;
    logic [ADDR_W-1:0]            clr_cnt_reg;

    logic                         wb_valid_reg;
    logic [ADDR_W-1:0]            wb_addr_reg;
    logic [INC_W-1:0]             inc_reg;
    logic [VAL_W-1:0]             mem_q_reg;

    logic [VAL_W-1:0]             canvas_mem [NPIX];

    logic                         accept;
    logic [sbcs_pkg::SCALE_W-1:0] sc;
    logic [EDGE_W-1:0]            edge_w;
    logic [RAD_W-1:0]             rad;
    logic signed [OFS_W-1:0]      rad_s;
    logic signed [sbcs_pkg::POS_W-1:0] in_x, in_y;
    logic                         paint_in, read_in;

    logic [DIV_W-1:0]             trial;
    logic                         qbit_x, qbit_y;

    logic signed [CRD_W-1:0]      px, py;
    logic                         pix_in;
    logic [RAD_W-1:0]             adx, ady;
    logic                         row_end, walk_end;
    logic                         div_end, clr_end, fin_go;

    logic                         mem_re, mem_we;
    logic [ADDR_W-1:0]            mem_raddr, mem_waddr;
    logic [VAL_W-1:0]             mem_wdata;
    logic [VAL_W:0]               wb_sum;
    logic                         issue;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = out_inside_reg;
    assign m_tdata   = 16'(out_value_reg);

    assign accept = s_tvalid && s_tready;
    assign sc     = (scale_reg == '0) ? sbcs_pkg::SCALE_W'(1) : scale_reg;
    assign edge_w = EDGE_W'(IMAGE_SIZE) * EDGE_W'(sc);
    assign rad    = (int'(radius_reg) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius_reg;
    assign rad_s  = signed'({1'b0, rad});
    assign in_x   = signed'(s_tdata[sbcs_pkg::POS_W-1:0]);
    assign in_y   = signed'(s_tdata[2*sbcs_pkg::POS_W-1:sbcs_pkg::POS_W]);

    assign paint_in = !in_x[sbcs_pkg::POS_W-1] && !in_y[sbcs_pkg::POS_W-1]
                   && (CMP_W'(in_x[MAG_W-1:0]) < CMP_W'(edge_w))
                   && (CMP_W'(in_y[MAG_W-1:0]) < CMP_W'(edge_w));
    assign read_in  = !in_x[sbcs_pkg::POS_W-1] && !in_y[sbcs_pkg::POS_W-1]
                   && (CMP_W'(in_x[MAG_W-1:0]) < CMP_W'(IMAGE_SIZE))
                   && (CMP_W'(in_y[MAG_W-1:0]) < CMP_W'(IMAGE_SIZE));

    assign trial  = DIV_W'(sc) << div_cnt_reg;
    assign qbit_x = DIV_W'(rem_x_reg) >= trial;
    assign qbit_y = DIV_W'(rem_y_reg) >= trial;

    assign px     = CRD_W'(signed'({1'b0, cx_reg})) + CRD_W'(dx_reg);
    assign py     = CRD_W'(signed'({1'b0, cy_reg})) + CRD_W'(dy_reg);
    assign pix_in = (px >= 0) && (px < CRD_W'(IMAGE_SIZE))
                 && (py >= 0) && (py < CRD_W'(IMAGE_SIZE));
    assign adx    = dx_reg[OFS_W-1] ? RAD_W'(-dx_reg) : RAD_W'(dx_reg);
    assign ady    = dy_reg[OFS_W-1] ? RAD_W'(-dy_reg) : RAD_W'(dy_reg);

    assign row_end  = dx_reg == rad_s;
    assign walk_end = row_end && (dy_reg == rad_s);
    assign div_end  = div_cnt_reg == '0;
    assign clr_end  = clr_cnt_reg == ADDR_W'(NPIX - 1);
    assign fin_go   = !m_tvalid_reg || m_tready;

    assign wb_sum = {1'b0, mem_q_reg} + (VAL_W + 1)'(inc_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sbcs_pkg::ST_INIT: begin
                if (clr_end) state_next = sbcs_pkg::ST_IDLE;
            end
            sbcs_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (s_tuser)
                        sbcs_pkg::FUNC_PAINT: begin
                            state_next = paint_in ? sbcs_pkg::ST_DIV : sbcs_pkg::ST_FIN;
                        end
                        sbcs_pkg::FUNC_CLEAR: state_next = sbcs_pkg::ST_CLEAR;
                        sbcs_pkg::FUNC_READ: begin
                            state_next = read_in ? sbcs_pkg::ST_READ : sbcs_pkg::ST_FIN;
                        end
                        default: state_next = sbcs_pkg::ST_FIN;
                    endcase
                end
            end
            sbcs_pkg::ST_DIV: begin
                if (div_end) state_next = sbcs_pkg::ST_PAINT;
            end
            sbcs_pkg::ST_PAINT: begin
                if (walk_end) state_next = sbcs_pkg::ST_FIN;
            end
            sbcs_pkg::ST_CLEAR: begin
                if (clr_end) state_next = sbcs_pkg::ST_FIN;
            end
            sbcs_pkg::ST_READ:   state_next = sbcs_pkg::ST_RDWAIT;
            sbcs_pkg::ST_RDWAIT: state_next = sbcs_pkg::ST_FIN;
            sbcs_pkg::ST_FIN: begin
                if (fin_go) state_next = sbcs_pkg::ST_IDLE;
            end
            default: state_next = sbcs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        issue     = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = ADDR_W'(cy_reg) * ADDR_W'(IMAGE_SIZE) + ADDR_W'(cx_reg);
        mem_we    = wb_valid_reg;
        mem_waddr = wb_addr_reg;
        mem_wdata = (wb_sum > (VAL_W + 1)'(sbcs_pkg::PIXEL_FULL))
                  ? sbcs_pkg::PIXEL_FULL : wb_sum[VAL_W-1:0];
        unique case (state_reg)
            sbcs_pkg::ST_IDLE: s_tready = 1'b1;
            sbcs_pkg::ST_PAINT: begin
                issue     = pix_in;
                mem_re    = pix_in;
                mem_raddr = ADDR_W'(py[QW-1:0]) * ADDR_W'(IMAGE_SIZE) + ADDR_W'(px[QW-1:0]);
            end
            sbcs_pkg::ST_READ: mem_re = 1'b1;
            sbcs_pkg::ST_INIT, sbcs_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            canvas_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q_reg <= canvas_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        inc_reg     <= sbcs_pkg::INC_LUT[{rad, adx, ady}];
        wb_addr_reg <= mem_raddr;

        unique case (state_reg)
            sbcs_pkg::ST_IDLE: begin
                rem_x_reg     <= in_x[MAG_W-1:0];
                rem_y_reg     <= in_y[MAG_W-1:0];
                cx_reg        <= in_x[QW-1:0];
                cy_reg        <= in_y[QW-1:0];
                div_cnt_reg   <= CNT_W'(QW - 1);
                res_value_reg <= '0;
                res_inside_reg <= (s_tuser == sbcs_pkg::FUNC_READ) && read_in;
            end
            sbcs_pkg::ST_DIV: begin
                if (qbit_x) rem_x_reg <= MAG_W'(DIV_W'(rem_x_reg) - trial);
                if (qbit_y) rem_y_reg <= MAG_W'(DIV_W'(rem_y_reg) - trial);
                cx_reg      <= {cx_reg[QW-2:0], qbit_x};
                cy_reg      <= {cy_reg[QW-2:0], qbit_y};
                div_cnt_reg <= div_cnt_reg - CNT_W'(1);
                dx_reg      <= -rad_s;
                dy_reg      <= -rad_s;
            end
            sbcs_pkg::ST_PAINT: begin
                if (row_end) begin
                    dx_reg <= -rad_s;
                    dy_reg <= dy_reg + OFS_W'(1);
                end else begin
                    dx_reg <= dx_reg + OFS_W'(1);
                end
                if (walk_end) res_inside_reg <= 1'b1;
            end
            sbcs_pkg::ST_RDWAIT: res_value_reg <= mem_q_reg;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= sbcs_pkg::ST_INIT;
            scale_reg      <= sbcs_pkg::SCALE_RESET;
            radius_reg     <= sbcs_pkg::RADIUS_RESET;
            m_tvalid_reg   <= 1'b0;
            wb_valid_reg   <= 1'b0;
            clr_cnt_reg    <= '0;
            out_inside_reg <= 1'b0;
            out_value_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            wb_valid_reg <= issue;

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_addr)
                    sbcs_pkg::CFG_SCALE:  scale_reg  <= cfg_data[sbcs_pkg::SCALE_W-1:0];
                    sbcs_pkg::CFG_RADIUS: radius_reg <= cfg_data[RAD_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (state_reg == sbcs_pkg::ST_INIT || state_reg == sbcs_pkg::ST_CLEAR) begin
                clr_cnt_reg <= clr_end ? '0 : clr_cnt_reg + ADDR_W'(1);
            end

            if (state_reg == sbcs_pkg::ST_FIN && fin_go) begin
                m_tvalid_reg   <= 1'b1;
                out_inside_reg <= res_inside_reg;
                out_value_reg  <= res_value_reg;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int GRID     = sbcs_pkg::IMAGE_SIZE_DEF;
    localparam int NPIX     = GRID * GRID;
    localparam int GAIN_NUM = 1408;
    localparam int FUNC_W   = sbcs_pkg::FUNC_W;
    localparam int POS_W    = sbcs_pkg::POS_W;
    localparam int VAL_W    = sbcs_pkg::VAL_W;
    localparam int SCALE_W  = sbcs_pkg::SCALE_W;
    localparam int RAD_W    = sbcs_pkg::RAD_W;
    localparam int CFG_AW   = sbcs_pkg::CFG_AW;
    localparam int CFG_DW   = sbcs_pkg::CFG_DW;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic             in_canvas;
        logic [VAL_W-1:0] pixel_value;
    } stamp_result_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata   = '0;
    logic [FUNC_W-1:0] s_tuser   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [15:0]       m_tdata;
    logic              m_tuser;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_AW-1:0] cfg_addr  = '0;
    logic [CFG_DW-1:0] cfg_data  = '0;

    logic [VAL_W-1:0]   canvas_m [NPIX];
    logic [SCALE_W-1:0] scale_m;
    logic [RAD_W-1:0]   radius_m;
    stamp_result_t      canvas_replies [$];
    int                 err_count  = 0;
    int                 stall_left = 0;
    bit                 idle_en    = 1'b1;
    int                 last_cx    = 0;
    int                 last_cy    = 0;

    soft_brush_canvas_stamp u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // largest k with r1*(1413 - 10k) >= 1408*sqrt(dist_sq): round half up of 140.8*(1 - d/r1)
    function automatic int brush_gain(input int dist_sq, input int r1);
        longint lhs;
        for (int k = 141; k > 0; k--) begin
            lhs = longint'(r1) * longint'(1413 - 10 * k);
            if (lhs >= 0 && lhs * lhs >= longint'(GAIN_NUM * GAIN_NUM) * longint'(dist_sq))
                return k;
        end
        return 0;
    endfunction

    function automatic stamp_result_t predict_stamp(input logic [FUNC_W-1:0] f,
                                                    input logic signed [POS_W-1:0] x,
                                                    input logic signed [POS_W-1:0] y);
        stamp_result_t res;
        int xi, yi, sc, lim, rad, px, py, sum;
        res = '0;
        xi  = x;
        yi  = y;
        case (f)
            sbcs_pkg::FUNC_PAINT: begin
                sc  = (scale_m == 0) ? 1 : int'(scale_m);
                lim = GRID * sc;
                rad = (int'(radius_m) > sbcs_pkg::MAX_RADIUS_DEF) ? sbcs_pkg::MAX_RADIUS_DEF
                                                                  : int'(radius_m);
                if (xi >= 0 && xi < lim && yi >= 0 && yi < lim) begin
                    res.in_canvas = 1'b1;
                    last_cx = xi / sc;
                    last_cy = yi / sc;
                    for (int dy = -rad; dy <= rad; dy++) begin
                        for (int dx = -rad; dx <= rad; dx++) begin
                            px = last_cx + dx;
                            py = last_cy + dy;
                            if (px >= 0 && px < GRID && py >= 0 && py < GRID) begin
                                sum = int'(canvas_m[py * GRID + px])
                                    + brush_gain(dx * dx + dy * dy, rad + 1);
                                canvas_m[py * GRID + px] = (sum > 256) ? sbcs_pkg::PIXEL_FULL
                                                                       : VAL_W'(sum);
                            end
                        end
                    end
                end
            end
            sbcs_pkg::FUNC_CLEAR: begin
                foreach (canvas_m[i]) canvas_m[i] = '0;
            end
            sbcs_pkg::FUNC_READ: begin
                if (xi >= 0 && xi < GRID && yi >= 0 && yi < GRID) begin
                    res.in_canvas   = 1'b1;
                    res.pixel_value = canvas_m[yi * GRID + xi];
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic log_error(input string what, input stamp_result_t want,
                             input logic got_in, input logic [15:0] got_px);
        err_count++;
        if (err_count <= 10)
            $display("%0t %s: expected in_canvas=%0b pixel=%0d, got in_canvas=%0b pixel=%0d",
                     $time, what, want.in_canvas, want.pixel_value, got_in, got_px);
    endtask

    task automatic issue_cmd(input logic [FUNC_W-1:0] f, input int x, input int y);
        stamp_result_t exp_res;
        if (idle_en && $urandom_range(0, 2) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {6'b0, POS_W'(y), POS_W'(x)};
        do @(posedge aclk); while (!s_tready);
        exp_res = predict_stamp(f, POS_W'(x), POS_W'(y));
        canvas_replies.insert(canvas_replies.size(), exp_res);
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (canvas_replies.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_config(input int scale, input int radius);
        logic [CFG_DW-1:0] word;
        word = CFG_DW'($urandom);
        word[RAD_W-1:0] = RAD_W'(radius);
        cfg_valid <= 1'b1;
        cfg_addr  <= sbcs_pkg::CFG_SCALE;
        cfg_data  <= CFG_DW'(scale);
        do @(posedge aclk); while (!cfg_ready);
        scale_m  = SCALE_W'(scale);
        cfg_addr <= sbcs_pkg::CFG_RADIUS;
        cfg_data <= word;
        do @(posedge aclk); while (!cfg_ready);
        radius_m = word[RAD_W-1:0];
        cfg_valid <= 1'b0;
    endtask

    task automatic random_cmd();
        int sel, lim, x, y;
        lim = GRID * ((scale_m == 0) ? 1 : int'(scale_m));
        sel = $urandom_range(0, 99);
        x   = $urandom_range(0, 8191) - 4096;
        y   = $urandom_range(0, 8191) - 4096;
        if (sel < 50) begin
            case ($urandom_range(0, 9))
                0: begin
                end
                1: begin
                    x = ($urandom_range(0, 1) == 1) ? lim - 1 + $urandom_range(0, 1)
                                                    : $urandom_range(0, 1) - 1;
                    y = ($urandom_range(0, 1) == 1) ? lim - 1 + $urandom_range(0, 1)
                                                    : $urandom_range(0, 1) - 1;
                end
                default: begin
                    x = $urandom_range(0, lim - 1);
                    y = $urandom_range(0, lim - 1);
                end
            endcase
            issue_cmd(sbcs_pkg::FUNC_PAINT, x, y);
        end else if (sel < 92) begin
            case ($urandom_range(0, 9))
                0: begin
                end
                1, 2, 3, 4: begin
                    x = last_cx + $urandom_range(0, 16) - 8;
                    y = last_cy + $urandom_range(0, 16) - 8;
                end
                default: begin
                    x = $urandom_range(0, GRID - 1);
                    y = $urandom_range(0, GRID - 1);
                end
            endcase
            issue_cmd(sbcs_pkg::FUNC_READ, x, y);
        end else if (sel < 96) begin
            issue_cmd(sbcs_pkg::FUNC_CLEAR, x, y);
        end else begin
            issue_cmd(FUNC_UNUSED, x, y);
        end
    endtask

    task automatic test_defaults();
        issue_cmd(sbcs_pkg::FUNC_READ, 0, 0);
        issue_cmd(sbcs_pkg::FUNC_PAINT, 0, 0);
        issue_cmd(sbcs_pkg::FUNC_READ, 0, 0);
        issue_cmd(sbcs_pkg::FUNC_READ, 1, 1);
        issue_cmd(sbcs_pkg::FUNC_PAINT, 279, 279);
        issue_cmd(sbcs_pkg::FUNC_PAINT, 280, 5);
        issue_cmd(sbcs_pkg::FUNC_PAINT, -1, 0);
        issue_cmd(sbcs_pkg::FUNC_PAINT, -4096, 4095);
        issue_cmd(sbcs_pkg::FUNC_READ, 27, 27);
        issue_cmd(sbcs_pkg::FUNC_READ, 28, 0);
        issue_cmd(sbcs_pkg::FUNC_READ, -4096, -4096);
        issue_cmd(sbcs_pkg::FUNC_READ, 4095, 4095);
        issue_cmd(FUNC_UNUSED, 4095, -4096);
        issue_cmd(sbcs_pkg::FUNC_CLEAR, 0, 0);
        issue_cmd(sbcs_pkg::FUNC_READ, 27, 27);
        drain_replies();
    endtask

    task automatic test_extreme_settings();
        set_config(0, sbcs_pkg::MAX_RADIUS_DEF);
        issue_cmd(sbcs_pkg::FUNC_PAINT, 13, 13);
        issue_cmd(sbcs_pkg::FUNC_PAINT, 13, 13);
        issue_cmd(sbcs_pkg::FUNC_READ, 13, 13);
        issue_cmd(sbcs_pkg::FUNC_READ, 20, 13);
        issue_cmd(sbcs_pkg::FUNC_READ, 6, 6);
        issue_cmd(sbcs_pkg::FUNC_READ, 20, 20);
        drain_replies();
        set_config(sbcs_pkg::SCALE_MAX, 0);
        issue_cmd(sbcs_pkg::FUNC_PAINT, GRID * sbcs_pkg::SCALE_MAX - 1, 0);
        issue_cmd(sbcs_pkg::FUNC_PAINT, GRID * sbcs_pkg::SCALE_MAX, 0);
        issue_cmd(sbcs_pkg::FUNC_READ, 27, 0);
        drain_replies();
    endtask

    task automatic test_random_phases(input int n_phases, input int per_phase);
        int scale, radius;
        for (int p = 0; p < n_phases; p++) begin
            case ($urandom_range(0, 5))
                0: scale = 0;
                1: scale = 1;
                2: scale = sbcs_pkg::SCALE_MAX;
                3: scale = 64;
                default: scale = $urandom_range(1, 64);
            endcase
            radius  = (p == 0) ? sbcs_pkg::MAX_RADIUS_DEF : (p == 1) ? 0 : $urandom_range(0, 7);
            idle_en = ($urandom_range(0, 3) != 0);
            set_config(scale, radius);
            repeat (per_phase) random_cmd();
            drain_replies();
        end
    endtask

    task automatic test_steady_stream(input int n_items);
        idle_en = 1'b0;
        set_config($urandom_range(1, 16), $urandom_range(0, 7));
        repeat (n_items) random_cmd();
        drain_replies();
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_en && $urandom_range(0, 19) == 0) begin
            stall_left <= $urandom_range(0, 12);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        stamp_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (canvas_replies.size() == 0) begin
                log_error("unexpected beat", '0, m_tuser, m_tdata);
            end else begin
                want = canvas_replies.pop_front();
                if (m_tuser !== want.in_canvas || m_tdata !== 16'(want.pixel_value))
                    log_error("mismatch", want, m_tuser, m_tdata);
            end
        end
    end

    initial begin
        foreach (canvas_m[i]) canvas_m[i] = '0;
        scale_m  = sbcs_pkg::SCALE_RESET;
        radius_m = sbcs_pkg::RADIUS_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_defaults();
        test_extreme_settings();
        test_random_phases(8, 80);
        test_steady_stream(100);
        repeat (50) @(posedge aclk);
        if (canvas_replies.size() != 0) begin
            $display("%0d results never arrived", canvas_replies.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #30000000;
        $display("status: fail");
        $finish;
    end

endmodule
